// ===== hdl/vss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the VAD segment smoother.
// No dependencies.
package vss_pkg;

  localparam int FRAME_INDEX_BITS_DEF = 24;
  localparam int SEG_BITS             = 24;
  localparam int CFG_BITS             = 16;
  localparam int CFG_INDEX_BITS       = 1;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [CFG_BITS-1:0]       cfg_word_t;
  typedef logic [SEG_BITS-1:0]       seg_idx_t;

  localparam cfg_index_t REG_MERGE_GAP  = 1'd0;
  localparam cfg_index_t REG_MIN_LENGTH = 1'd1;

  localparam cfg_word_t MERGE_GAP_RESET  = 16'd25;
  localparam cfg_word_t MIN_LENGTH_RESET = 16'd50;

endpackage

// ===== hdl/vad_segment_smoother.sv =====
`timescale 1ns / 1ps
// VAD segment smoother top level: speech run tracking, gap merge, length filter.
// Depends on vss_pkg.

// One speech/silence tag is taken per clock;
// the run state (frame counter, open segment bounds) updates in a single
// compare-and-select stage. A reported segment lands in an output register
// backed by one skid entry, so input keeps flowing while a result waits;
// input stalls only when both hold results. Segments are closed once the
// silence since the last speech frame reaches merge_gap_frames or on end of
// stream, and reported only if at least min_length_frames long. Frame
// indices wrap at 2^FRAME_INDEX_BITS and are reported in their low 24 bits.
module vad_segment_smoother #(
  parameter int FRAME_INDEX_BITS = vss_pkg::FRAME_INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  vss_pkg::cfg_index_t  cfg_index,
  input  vss_pkg::cfg_word_t   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 is_speech,
  input  logic                 end_of_stream,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vss_pkg::seg_idx_t    seg_start,
  output vss_pkg::seg_idx_t    seg_end
);

  localparam int N = FRAME_INDEX_BITS;
  localparam int W = (N > vss_pkg::CFG_BITS) ? N : vss_pkg::CFG_BITS;
  localparam logic [W-1:0] IDX_MAX = W'((64'd1 << N) - 64'd1);

  vss_pkg::cfg_word_t merge_gap_frames;
  vss_pkg::cfg_word_t min_length_frames;

  logic [N-1:0] frame_index, frame_index_next;
  logic         have_pending, have_pending_next;
  logic [N-1:0] pending_start, pending_start_next;
  logic [N-1:0] pending_end, pending_end_next;

  logic                 skid_valid;
  vss_pkg::seg_idx_t    skid_start, skid_end;

  logic         accept;
  logic         hp_upd;
  logic [N-1:0] start_upd, end_upd;
  logic [N-1:0] gap_dist, len;
  logic [W-1:0] limit;
  logic         close_try;
  logic         res_valid;
  vss_pkg::seg_idx_t res_start, res_end;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hp_upd    = have_pending;
    start_upd = pending_start;
    end_upd   = pending_end;
    if (is_speech) begin
      hp_upd  = 1'b1;
      end_upd = frame_index;
      if (!have_pending) begin
        start_upd = frame_index;
      end
    end
    gap_dist = frame_index - pending_end;
    limit = (W'(merge_gap_frames) > IDX_MAX) ? IDX_MAX : W'(merge_gap_frames);
    close_try = end_of_stream || (!is_speech && have_pending && (W'(gap_dist) >= limit));
    len       = end_upd - start_upd + N'(1);
    res_valid = accept && close_try && hp_upd
                && (W'(len) >= W'(min_length_frames));
    res_start = vss_pkg::seg_idx_t'(start_upd);
    res_end   = vss_pkg::seg_idx_t'(end_upd);

    have_pending_next  = close_try ? 1'b0 : hp_upd;
    pending_start_next = start_upd;
    pending_end_next   = end_upd;
    frame_index_next   = end_of_stream ? '0 : frame_index + N'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_gap_frames  <= vss_pkg::MERGE_GAP_RESET;
      min_length_frames <= vss_pkg::MIN_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        vss_pkg::REG_MERGE_GAP:  merge_gap_frames  <= cfg_wdata;
        vss_pkg::REG_MIN_LENGTH: min_length_frames <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index   <= '0;
      have_pending  <= 1'b0;
      pending_start <= '0;
      pending_end   <= '0;
    end else if (accept) begin
      frame_index   <= frame_index_next;
      have_pending  <= have_pending_next;
      pending_start <= pending_start_next;
      pending_end   <= pending_end_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      seg_start <= skid_valid ? skid_start : res_start;
      seg_end   <= skid_valid ? skid_end : res_end;
    end else if (res_valid) begin
      skid_start <= res_start;
      skid_end   <= res_end;
    end
  end

endmodule
